// ===== rtl/core/belt_retract_stall_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Belt retract stall detector assertion macros
// Concurrent assertion wrappers used by the top level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef BELT_RETRACT_STALL_DETECTOR_ASSERT_SVH
`define BELT_RETRACT_STALL_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define BRSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, also during reset.
`define BRSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BRSD_ASSERT(lbl, prop, msg)
`define BRSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/brsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Belt retract stall detector package
// Widths, reset values, register codes and shared types of the block.
// ----------------------------------------------------------------------------
package brsd_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned SPEED_MAX_DEF   = 1023;

  // Fixed field widths.
  localparam int unsigned DRIVE_W  = 10;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RISE_W   = 12;
  localparam int unsigned HIT_W    = 8;
  localparam int unsigned FRAC_W   = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Detector constants.
  localparam int unsigned SPEED_ARM      = 15;
  localparam int unsigned BASE_RESET_INT = 700;
  localparam logic [HIT_W-1:0] HIT_MAX   = 8'd255;
  localparam logic [HIT_W-1:0] HIT_LIMIT = 8'd2;

  // Register reset values.
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 12'd1300;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd6554;
  localparam logic [RISE_W-1:0]   RISE_RST   = 12'd20;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_LIMIT  = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_RISE   = 2'd2
  } brsd_reg_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [LIMIT_W-1:0]  limit;
    logic [WEIGHT_W-1:0] weight;
    logic [RISE_W-1:0]   rise;
  } brsd_cfg_t;

  // One result beat.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               done;
  } brsd_res_t;

endpackage

// ===== rtl/core/brsd_if.sv =====
// ----------------------------------------------------------------------------
// Belt retract stall detector channels
// Valid/ready interfaces for the sample input and the drive result.
// ----------------------------------------------------------------------------

// Input channel: one beat per control tick.
interface brsd_in_if
  import brsd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SAMPLE_BITS-1:0] current_sample;
  logic                   coin_bit;

  modport source (output valid, func, current_sample, coin_bit, input ready);
  modport sink   (input valid, func, current_sample, coin_bit, output ready);
endinterface

// Result channel: one beat per input beat.
interface brsd_out_if
  import brsd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] pull_drive;
  logic               pull_done;
  logic               zero_position;

  modport source (output valid, pull_drive, pull_done, zero_position, input ready);
  modport sink   (input valid, pull_drive, pull_done, zero_position, output ready);
endinterface

// ===== rtl/core/brsd_regs.sv =====
// ----------------------------------------------------------------------------
// Belt retract stall detector registers
// APB-style register file holding the limit, weight and rise threshold.
// ----------------------------------------------------------------------------
module brsd_regs
  import brsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output brsd_cfg_t         cfg_o
);

  logic [LIMIT_W-1:0]  limit_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [RISE_W-1:0]   rise_q;
  logic                wr_en;
  brsd_reg_e           reg_sel;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = brsd_reg_e'(paddr[3:2]);

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      weight_q <= WEIGHT_RST;
      rise_q   <= RISE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
        REG_WEIGHT: weight_q <= pwdata[WEIGHT_W-1:0];
        REG_RISE:   rise_q   <= pwdata[RISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      REG_LIMIT:  prdata = CFG_DW'(limit_q);
      REG_WEIGHT: prdata = CFG_DW'(weight_q);
      REG_RISE:   prdata = CFG_DW'(rise_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.limit  = limit_q;
  assign cfg_o.weight = weight_q;
  assign cfg_o.rise   = rise_q;

endmodule

// ===== rtl/core/brsd_core.sv =====
// ----------------------------------------------------------------------------
// Belt retract stall detector datapath
// Speed ramp, current baseline, hit counter and stall decision in one pass.
// ----------------------------------------------------------------------------
module brsd_core
  import brsd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned SPEED_MAX   = SPEED_MAX_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   func_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   coin_i,
  input  brsd_cfg_t              cfg_i,
  output brsd_res_t              res_o
);

  // The integer part is wide enough for both the samples and the reset level.
  localparam int unsigned INT_W   = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int unsigned BASE_W  = INT_W + FRAC_W;
  localparam int unsigned DIFF_W  = BASE_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + WEIGHT_W + 1;
  localparam int unsigned THR_W   = RISE_W + FRAC_W;
  localparam int unsigned CMP_W   = ((BASE_W > THR_W) ? BASE_W : THR_W) + 1;
  localparam int unsigned CUR_W   = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
  localparam int unsigned SPEED_W = $clog2(SPEED_MAX + 1);

  localparam logic [BASE_W-1:0]         BASE_RESET = BASE_W'(BASE_RESET_INT) << FRAC_W;
  localparam logic [SPEED_W-1:0]        SPEED_TOP  = SPEED_W'(SPEED_MAX);
  localparam logic [SPEED_W-1:0]        SPEED_ARMV = SPEED_W'(SPEED_ARM);
  localparam logic signed [PROD_W-1:0]  HALF       = PROD_W'(1) << (FRAC_W - 1);

  logic [SPEED_W-1:0]       speed_q, speed_d, speed_inc;
  logic [BASE_W-1:0]        base_q, base_d, base_new, xs;
  logic [HIT_W-1:0]         hit_q, hit_d, hit_new;
  logic signed [DIFF_W-1:0] diff;
  logic signed [WEIGHT_W:0] wgt;
  logic signed [PROD_W-1:0] prod, delta;
  logic [CMP_W-1:0]         thr;
  logic                     rise_hit, over_limit, done;

  // Speed ramps by one on a coin, holding at the top.
  assign speed_inc = (coin_i && (speed_q < SPEED_TOP)) ? speed_q + SPEED_W'(1) : speed_q;

  // Baseline: b + round(w * (x - b)), the same as the weighted average.
  assign xs       = BASE_W'(sample_i) << FRAC_W;
  assign diff     = $signed({1'b0, xs}) - $signed({1'b0, base_q});
  assign wgt      = $signed({1'b0, cfg_i.weight});
  assign prod     = PROD_W'(wgt) * PROD_W'(diff);
  assign delta    = (prod + HALF) >>> FRAC_W;
  assign base_new = base_q + delta[BASE_W-1:0];

  // A hit is a sample above the new baseline by more than the rise threshold.
  assign thr      = CMP_W'(cfg_i.rise) << FRAC_W;
  assign rise_hit = CMP_W'(xs) > (CMP_W'(base_new) + thr);
  assign hit_new  = !rise_hit ? '0 :
                    (hit_q == HIT_MAX) ? hit_q : hit_q + HIT_W'(1);

  // Stall decision, armed once the speed is past its threshold.
  assign over_limit = CUR_W'(sample_i) > CUR_W'(cfg_i.limit);
  assign done       = !func_i && (speed_inc > SPEED_ARMV) &&
                      (over_limit || (hit_new > HIT_LIMIT));

  // Next state.
  always_comb begin
    if (func_i) begin
      speed_d = '0;
      base_d  = BASE_RESET;
      hit_d   = '0;
    end else if (done) begin
      speed_d = '0;
      base_d  = BASE_RESET;
      hit_d   = hit_new;
    end else begin
      speed_d = speed_inc;
      base_d  = base_new;
      hit_d   = hit_new;
    end
  end

  // Result of this tick.
  assign res_o.drive = (func_i || done) ? '0 : DRIVE_W'(speed_inc);
  assign res_o.done  = done;

  // State advances once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      base_q  <= BASE_RESET;
      hit_q   <= '0;
    end else if (step_i) begin
      speed_q <= speed_d;
      base_q  <= base_d;
      hit_q   <= hit_d;
    end
  end

endmodule

// ===== rtl/core/belt_retract_stall_detector.sv =====
// ----------------------------------------------------------------------------
// Belt retract stall detector
// Ramps the retract drive and ends the pull when the motor current shows
// the belt has come tight.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one beat per control tick: func (0 pull tick, 1 restore),
//   the motor current sample and a coin bit that raises the pull speed.
//   out_if returns exactly one beat per input beat: the drive level, the
//   done flag and the encoder zero strobe, which equals done.
//   A beat is registered at the input, evaluated in one pass through the
//   baseline multiplier and compare, and then lands in the output register,
//   from which its result is offered. One beat is accepted every cycle
//   while the receiver keeps up; the state of speed, baseline and hit count
//   is updated once per beat.
//   When the receiver stalls, the output register holds its beat, the input
//   register fills, and in_if.ready drops until the output drains.
//   After reset the speed and hit count are zero, the baseline is 700 and
//   the registers hold their documented defaults. Write the registers over
//   the APB port only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "belt_retract_stall_detector_assert.svh"

module belt_retract_stall_detector
  import brsd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned SPEED_MAX   = SPEED_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  brsd_in_if.sink           in_if,
  brsd_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  brsd_cfg_t              cfg;
  brsd_res_t              res;
  logic                   in_valid_q, out_valid_q;
  logic                   func_q, coin_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [DRIVE_W-1:0]     drive_q;
  logic                   done_q;
  logic                   advance, step;

  // Configuration registers.
  brsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the output register frees up when empty or being taken.
  assign advance     = !out_valid_q || out_if.ready;
  assign step        = in_valid_q && advance;
  assign in_if.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      func_q   <= in_if.func;
      sample_q <= in_if.current_sample;
      coin_q   <= in_if.coin_bit;
    end
  end

  // Datapath and detector state.
  brsd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SPEED_MAX   (SPEED_MAX)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .func_i   (func_q),
    .sample_i (sample_q),
    .coin_i   (coin_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      drive_q <= res.drive;
      done_q  <= res.done;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.pull_drive    = drive_q;
  assign out_if.pull_done     = done_q;
  assign out_if.zero_position = done_q;

  // A finished pull never drives the motor.
  `BRSD_ASSERT(a_done_no_drive, (out_valid_q && done_q) |-> (drive_q == '0), "drive on done")
  // A blocked input beat stays put until the output register frees up.
  `BRSD_ASSERT(a_in_hold, (in_valid_q && !advance) |=> (in_valid_q && $stable(sample_q)), "input beat lost")
  // A result beat is only produced from a registered input beat.
  `BRSD_ASSERT(a_out_src, ($rose(out_valid_q)) |-> $past(in_valid_q), "result without input")

endmodule

// ===== verif/brsd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Belt retract stall detector predictor
// Bit-exact model of the retract speed ramp, the current baseline and the
// hit counter, plus the queue of drive beats the block still owes us.
// ----------------------------------------------------------------------------
package brsd_tb_pkg;
  import brsd_pkg::*;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;

  // Input beat function codes.
  localparam logic FUNC_PULL    = 1'b0;
  localparam logic FUNC_RESTORE = 1'b1;

  // Address with no register behind it; writes there must be ignored.
  localparam logic [CFG_AW-1:0] SPARE_ADDR = CFG_AW'(12);

  localparam int unsigned REPORT_MAX = 10;

  // One expected result beat.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               done;
    logic               zero;
  } drive_beat_t;

  class retract_tracker;
    brsd_cfg_t       cfg;
    int unsigned     speed_now;
    bit [63:0]       baseline_q16;
    logic [HIT_W-1:0] hit_run;
    drive_beat_t     expected_beats[$];

    int unsigned n_ticks;
    int unsigned n_restores;
    int unsigned n_dones;
    int unsigned n_speed_sat;
    int unsigned n_hit_sat;
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      cfg.limit  = LIMIT_RST;
      cfg.weight = WEIGHT_RST;
      cfg.rise   = RISE_RST;
      restore();
    endfunction

    // Speed, baseline and hit run go back to their idle values.
    function void restore();
      speed_now    = 0;
      baseline_q16 = 64'(BASE_RESET_INT) << FRAC_W;
      hit_run      = '0;
    endfunction

    function void record_error(string msg);
      n_errors++;
      if (n_errors <= REPORT_MAX) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endfunction

    // A completed register write; unknown indexes leave everything alone.
    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (addr[CFG_AW-1:2])
        REG_LIMIT:  cfg.limit  = data[LIMIT_W-1:0];
        REG_WEIGHT: cfg.weight = data[WEIGHT_W-1:0];
        REG_RISE:   cfg.rise   = data[RISE_W-1:0];
        default: ;
      endcase
    endfunction

    // A register read must return the field zero-extended.
    function void check_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] got);
      logic [CFG_DW-1:0] want;
      case (addr[CFG_AW-1:2])
        REG_LIMIT:  want = CFG_DW'(cfg.limit);
        REG_WEIGHT: want = CFG_DW'(cfg.weight);
        REG_RISE:   want = CFG_DW'(cfg.rise);
        default:    return;
      endcase
      if (got !== want) begin
        record_error($sformatf("register at 0x%0h: expected %0d, got %0d", addr, want, got));
      end
    endfunction

    // Advance the model by one accepted input beat and queue its result.
    function void accept_tick(logic func, logic [SAMPLE_W-1:0] x, logic coin);
      bit [63:0]   xs;
      bit [63:0]   w;
      drive_beat_t beat;
      beat = '0;
      n_ticks++;
      if (func == FUNC_RESTORE) begin
        restore();
        n_restores++;
      end else begin
        if (coin && speed_now < SPEED_MAX_DEF) speed_now++;
        if (speed_now == SPEED_MAX_DEF) n_speed_sat++;
        beat.drive = DRIVE_W'(speed_now);

        // Exponential baseline, Q0.16 weight on the new sample, round half up.
        xs = 64'(x) << FRAC_W;
        w  = 64'(cfg.weight);
        baseline_q16 = (w * xs + ((64'd1 << FRAC_W) - w) * baseline_q16 +
                        (64'd1 << (FRAC_W - 1))) >> FRAC_W;

        // Consecutive rises above the updated baseline.
        if (xs > baseline_q16 + (64'(cfg.rise) << FRAC_W)) begin
          if (hit_run != HIT_MAX) hit_run++;
        end else begin
          hit_run = '0;
        end
        if (hit_run == HIT_MAX) n_hit_sat++;

        // Once armed, an absolute overcurrent or a long rise ends the pull.
        if (speed_now > SPEED_ARM && (x > cfg.limit || hit_run > HIT_LIMIT)) begin
          beat.drive   = '0;
          beat.done    = 1'b1;
          beat.zero    = 1'b1;
          speed_now    = 0;
          baseline_q16 = 64'(BASE_RESET_INT) << FRAC_W;
          n_dones++;
        end
      end
      expected_beats.push_back(beat);
    endfunction

    // Compare one received result beat with the oldest expected one.
    function void check_drive(logic [DRIVE_W-1:0] drive, logic done, logic zero);
      drive_beat_t want;
      if (expected_beats.size() == 0) begin
        record_error($sformatf("result beat drive=%0d done=%0d with nothing expected",
                               drive, done));
        return;
      end
      want = expected_beats.pop_front();
      n_checked++;
      if (drive !== want.drive) begin
        record_error($sformatf("pull_drive expected %0d, got %0d", want.drive, drive));
      end
      if (done !== want.done) begin
        record_error($sformatf("pull_done expected %0d, got %0d", want.done, done));
      end
      if (zero !== want.zero) begin
        record_error($sformatf("zero_position expected %0d, got %0d", want.zero, zero));
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Belt retract stall detector testbench
// Drives sample beats and register writes into the detector, predicts every
// drive beat with a bit-exact model and checks the results in order, under
// several sender and receiver stall patterns and register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import brsd_pkg::*;
  import brsd_tb_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  // Margin left after every owed result beat has come back.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int unsigned    src_gap_pct;
  int unsigned    sink_stall_pct;
  retract_tracker sb;

  brsd_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  brsd_out_if out_ch ();

  belt_retract_stall_detector #(
    .SAMPLE_BITS(SAMPLE_W),
    .SPEED_MAX  (SPEED_MAX_DEF)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  wire in_beat  = in_ch.valid & in_ch.ready;
  wire out_beat = out_ch.valid & out_ch.ready;
  wire cfg_beat = psel & penable & pready;

  always #(HALF_PERIOD) clk = ~clk;

  // Result side: check each beat taken, then pick the next ready level.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_beat) begin
        sb.check_drive(out_ch.pull_drive, out_ch.pull_done, out_ch.zero_position);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Give up when no beat of any kind has moved for a long stretch.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_beat || out_beat || cfg_beat) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No beat moved for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CFG_AW-1:0] reg_addr(brsd_reg_e r);
    return CFG_AW'({r, 2'b00});
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(longint v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  // Current baseline rounded to converter counts.
  function automatic longint baseline_level();
    return longint'((sb.baseline_q16 + 64'd32768) >> FRAC_W);
  endfunction

  // APB write: setup phase, access phase, then a return to idle.
  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!cfg_beat);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!cfg_beat);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register with junk in the unused upper bits, then read it back.
  task automatic program_reg(input brsd_reg_e r, input logic [15:0] value);
    logic [CFG_DW-1:0] rd;
    apb_write(reg_addr(r), {16'($urandom), value});
    apb_read(reg_addr(r), rd);
    sb.check_reg(reg_addr(r), rd);
  endtask

  // Present one input beat after a random gap and wait until it is taken.
  task automatic send_beat(input logic func, input logic [SAMPLE_W-1:0] x, input logic coin);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= func;
    in_ch.current_sample <= x;
    in_ch.coin_bit       <= coin;
    do @(posedge clk); while (!in_beat);
    sb.accept_tick(func, x, coin);
  endtask

  // Stop sending and wait until every owed result beat has come back.
  task automatic hold_off();
    in_ch.valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [LIMIT_W-1:0] limit, input logic [WEIGHT_W-1:0] weight,
                           input logic [RISE_W-1:0] rise);
    hold_off();
    program_reg(REG_LIMIT, 16'(limit));
    program_reg(REG_WEIGHT, weight);
    program_reg(REG_RISE, 16'(rise));
  endtask

  // Arbitrary beat, restores included, samples biased toward the extremes.
  task automatic send_noise();
    logic [SAMPLE_W-1:0] x;
    case ($urandom_range(3))
      0:       x = '0;
      1:       x = SAMPLE_W'(SAMPLE_MAX);
      default: x = SAMPLE_W'($urandom);
    endcase
    send_beat(($urandom_range(99) < 10) ? FUNC_RESTORE : FUNC_PULL, x, 1'($urandom));
  endtask

  // A typical retract: optional restore, a ramp with quiet current, then a
  // stall shown as an overcurrent spike or a run of rising samples, or else loose beats.
  task automatic send_pull();
    int unsigned ramp;
    if ($urandom_range(1)) send_beat(FUNC_RESTORE, SAMPLE_W'($urandom), 1'($urandom));
    ramp = $urandom_range(40, 12);
    repeat (ramp) begin
      send_beat(FUNC_PULL, clamp_sample(baseline_level() + longint'($urandom_range(16)) - 8),
                $urandom_range(99) < 85);
    end
    case ($urandom_range(2))
      0: send_beat(FUNC_PULL, clamp_sample(longint'(sb.cfg.limit) + 1 +
                   longint'($urandom_range(300))), 1'b1);
      1: repeat ($urandom_range(5, 2)) begin
           send_beat(FUNC_PULL, clamp_sample(baseline_level() + longint'(sb.cfg.rise) + 1 +
                     longint'($urandom_range(60))), 1'($urandom));
         end
      default: repeat ($urandom_range(5, 1)) send_noise();
    endcase
  endtask

  // Mostly whole retract sequences, some loose beats; optionally drain halfway.
  task automatic pull_traffic(input int unsigned n_beats, input bit pause_midway);
    int unsigned start;
    bit          paused;
    start  = sb.n_ticks;
    paused = 1'b0;
    while (sb.n_ticks - start < n_beats) begin
      if ($urandom_range(99) < 80) send_pull();
      else send_noise();
      if (pause_midway && !paused && sb.n_ticks - start >= n_beats / 2) begin
        hold_off();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [CFG_DW-1:0] rd;
    brsd_reg_e         r;

    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_PULL;
    in_ch.current_sample = '0;
    in_ch.coin_bit       = 1'b0;
    out_ch.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    src_gap_pct          = 0;
    sink_stall_pct       = 0;
    sb                   = new();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers must come out of reset at their defaults.
    r = r.first();
    repeat (r.num()) begin
      apb_read(reg_addr(r), rd);
      sb.check_reg(reg_addr(r), rd);
      r = r.next();
    end

    // Directed: restore, sample extremes, a clean ramp to the arming speed,
    // the limit itself, then one count over it to end the pull.
    send_beat(FUNC_RESTORE, SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_beat(FUNC_PULL, '0, 1'b0);
    send_beat(FUNC_PULL, SAMPLE_W'(SAMPLE_MAX), 1'b0);
    send_beat(FUNC_PULL, SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_beat(FUNC_RESTORE, '0, 1'b0);
    repeat (SPEED_ARM + 1) send_beat(FUNC_PULL, SAMPLE_W'(BASE_RESET_INT), 1'b1);
    send_beat(FUNC_PULL, LIMIT_RST, 1'b0);
    send_beat(FUNC_PULL, LIMIT_RST + 12'd1, 1'b1);
    send_beat(FUNC_PULL, SAMPLE_W'(BASE_RESET_INT), 1'b0);

    // Default settings with a sparse sender.
    src_gap_pct = 74;
    pull_traffic(60, 1'b0);

    // Frozen baseline and no thresholds: the hit run climbs to its ceiling.
    configure(LIMIT_W'(SAMPLE_MAX), '0, '0);
    src_gap_pct    = 0;
    sink_stall_pct = 74;
    send_beat(FUNC_RESTORE, '0, 1'b0);
    repeat (262) begin
      send_beat(FUNC_PULL, SAMPLE_W'($urandom_range(SAMPLE_MAX, BASE_RESET_INT + 1)), 1'b0);
    end
    pull_traffic(30, 1'b0);

    // Nothing can end a pull here, so the speed runs into its ceiling.
    configure(LIMIT_W'(SAMPLE_MAX), '1, RISE_W'(SAMPLE_MAX));
    sink_stall_pct = 0;
    repeat (SPEED_MAX_DEF + 8) send_beat(FUNC_PULL, SAMPLE_W'($urandom), 1'b1);

    // Zero limit: any nonzero current ends an armed pull.
    configure('0, '1, '0);
    src_gap_pct    = 36;
    sink_stall_pct = 36;
    pull_traffic(40, 1'b0);

    // Random settings, with a full drain in the middle.
    configure(LIMIT_W'($urandom_range(2500, 800)), WEIGHT_W'($urandom),
              RISE_W'($urandom_range(200)));
    pull_traffic(50, 1'b1);

    // A write to the unused address must not disturb anything.
    hold_off();
    apb_write(SPARE_ADDR, $urandom);
    configure(LIMIT_W'($urandom_range(2500, 800)), WEIGHT_W'($urandom),
              RISE_W'($urandom_range(200)));
    src_gap_pct    = 0;
    sink_stall_pct = 74;
    pull_traffic(40, 1'b0);

    hold_off();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sample beats (%0d restores), checked %0d drive beats, %0d pulls ended.",
             sb.n_ticks, sb.n_restores, sb.n_checked, sb.n_dones);
    $display("Speed sat at its ceiling for %0d ticks, hit run at its ceiling for %0d ticks.",
             sb.n_speed_sat, sb.n_hit_sat);
    if (sb.n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", sb.n_errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/brsd_pkg.sv
rtl/core/brsd_if.sv
rtl/core/brsd_regs.sv
rtl/core/brsd_core.sv
rtl/core/belt_retract_stall_detector.sv
verif/brsd_tb_pkg.sv
verif/tb_top.sv
